### rtl/efcf_pkg.sv
`timescale 1ns / 1ps

package efcf_pkg;

   localparam int COUNT_SATURATE = 127;
   localparam int CNT_W          = $clog2(COUNT_SATURATE + 1);

   localparam int MODE_W    = 3;
   localparam int MAC_W     = 48;
   localparam int ETYPE_W   = 16;
   localparam int IP_W      = 32;
   localparam int PROTO_W   = 8;
   localparam int PORT_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 48;

   localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MAC   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ETYPE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_IP    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PROTO = 3'd4;
   localparam logic [MODE_W-1:0] MODE_PORT  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_MAC   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_ETYPE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_IP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_PROTO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_PORT  = 3'd5;

   localparam int POS_DST_MAC = 0;
   localparam int POS_SRC_MAC = 6;
   localparam int POS_TYPE_HI = 12;
   localparam int POS_TYPE_LO = 13;
   localparam int ETH_HDR     = 14;
   localparam int POS_PROTO   = 23;
   localparam int POS_SRC_IP  = 26;
   localparam int POS_DST_IP  = 30;
   localparam int IP_MIN_END  = 34;

   localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
   localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;
   localparam logic [3:0]         IHL_MASK   = 4'h0F;

   typedef logic [CNT_W-1:0] count_type;

endpackage

### rtl/ethernet_frame_capture_filter_top.sv
`timescale 1ns / 1ps

// Ethernet frame capture filter.
// req_ carries one frame byte per word in wire order, with tlast on the final
// byte. rsp_ returns one word per frame: the keep (1) or drop (0) verdict of
// the filter mode set through the csr_ write port.
// csr_ registers: 0 filter mode, 1 MAC, 2 EtherType, 3 IPv4 address,
// 4 IP protocol, 5 TCP/UDP port. Write them only while no frame is in flight.
// The verdict is registered and valid on rsp_ in the cycle after the last byte is taken.
// Throughput: one byte per cycle while req_tready is high; each byte passes one
// compare stage between the per-frame header registers and the verdict register.
// When the verdict register is full and rsp_tready is low, req_tready drops
// until the verdict is taken; the verdict holds steady meanwhile.
// Reset clears the configuration to zero (mode none), the per-frame state and
// the verdict register.
// The byte counter saturates at COUNT_SATURATE; later bytes are not inspected.
module ethernet_frame_capture_filter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] frame_byte
   input  logic                            req_tlast,   // end_of_frame
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [0] keep_frame, [7:1] zero
   input  logic                            csr_we,
   input  logic [efcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [efcf_pkg::CSR_W-1:0]      csr_wdata
);
   import efcf_pkg::*;

   logic [MODE_W-1:0]  filter_mode_ff;
   logic [MAC_W-1:0]   match_mac_ff;
   logic [ETYPE_W-1:0] match_etype_ff;
   logic [IP_W-1:0]    match_ip_ff;
   logic [PROTO_W-1:0] match_proto_ff;
   logic [PORT_W-1:0]  match_port_ff;

   count_type          byte_index_ff, byte_index_in;
   logic               dst_mac_eq_ff, dst_mac_eq_in;
   logic               src_mac_eq_ff, src_mac_eq_in;
   logic [ETYPE_W-1:0] type_field_ff, type_field_in;
   logic [3:0]         header_words_ff, header_words_in;
   logic [PROTO_W-1:0] proto_field_ff, proto_field_in;
   logic               src_ip_eq_ff, src_ip_eq_in;
   logic               dst_ip_eq_ff, dst_ip_eq_in;
   logic               src_port_eq_ff, src_port_eq_in;
   logic               dst_port_eq_ff, dst_port_eq_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               keep_ff, keep_in;

   logic               accept;
   count_type          pos;
   logic [CNT_W:0]     frame_len;
   logic [7:0]         b;
   count_type          port_t, port_off;
   logic [2:0]         mac_k;
   logic [1:0]         ip_k;
   logic [3:0]         hw_eff;
   logic               in_port;
   logic [7:0]         mac_sel, ip_sel, port_sel;
   logic               verdict;

   function automatic logic [7:0] sel_mac(input logic [MAC_W-1:0] mac, input logic [2:0] k);
      logic [7:0] r;
      unique case (k)
         3'd0:    r = mac[47:40];
         3'd1:    r = mac[39:32];
         3'd2:    r = mac[31:24];
         3'd3:    r = mac[23:16];
         3'd4:    r = mac[15:8];
         default: r = mac[7:0];
      endcase
      return r;
   endfunction

   function automatic logic [7:0] sel_ip(input logic [IP_W-1:0] ip, input logic [1:0] k);
      logic [7:0] r;
      unique case (k)
         2'd0:    r = ip[31:24];
         2'd1:    r = ip[23:16];
         2'd2:    r = ip[15:8];
         default: r = ip[7:0];
      endcase
      return r;
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, keep_ff};

   assign pos       = byte_index_ff;
   assign b         = req_tdata;
   assign frame_len = {1'b0, pos} + (CNT_W+1)'(1);

   assign mac_k    = 3'((pos < CNT_W'(POS_SRC_MAC)) ? pos : pos - CNT_W'(POS_SRC_MAC));
   assign ip_k     = 2'((pos < CNT_W'(POS_DST_IP)) ? pos - CNT_W'(POS_SRC_IP)
                                                   : pos - CNT_W'(POS_DST_IP));
   assign mac_sel  = sel_mac(match_mac_ff, mac_k);
   assign ip_sel   = sel_ip(match_ip_ff, ip_k);

   assign hw_eff   = (pos == CNT_W'(ETH_HDR)) ? (b[3:0] & IHL_MASK) : header_words_ff;
   assign port_t   = CNT_W'(ETH_HDR) + CNT_W'({hw_eff, 2'b00});
   assign port_off = pos - port_t;
   assign in_port  = (pos >= CNT_W'(ETH_HDR)) && (pos >= port_t) &&
                     (port_off < CNT_W'(4));
   assign port_sel = port_off[0] ? match_port_ff[7:0] : match_port_ff[15:8];

   always_comb begin
      dst_mac_eq_in   = dst_mac_eq_ff;
      src_mac_eq_in   = src_mac_eq_ff;
      type_field_in   = type_field_ff;
      header_words_in = header_words_ff;
      proto_field_in  = proto_field_ff;
      src_ip_eq_in    = src_ip_eq_ff;
      dst_ip_eq_in    = dst_ip_eq_ff;
      src_port_eq_in  = src_port_eq_ff;
      dst_port_eq_in  = dst_port_eq_ff;

      priority if (pos < CNT_W'(POS_SRC_MAC)) begin
         if (b != mac_sel) dst_mac_eq_in = 1'b0;
      end else if (pos < CNT_W'(POS_TYPE_HI)) begin
         if (b != mac_sel) src_mac_eq_in = 1'b0;
      end else if (pos == CNT_W'(POS_TYPE_HI)) begin
         type_field_in[15:8] = b;
      end else if (pos == CNT_W'(POS_TYPE_LO)) begin
         type_field_in[7:0] = b;
      end else if (pos == CNT_W'(ETH_HDR)) begin
         header_words_in = b[3:0] & IHL_MASK;
      end else if (pos == CNT_W'(POS_PROTO)) begin
         proto_field_in = b;
      end else if (pos >= CNT_W'(POS_SRC_IP) && pos < CNT_W'(POS_DST_IP)) begin
         if (b != ip_sel) src_ip_eq_in = 1'b0;
      end else if (pos >= CNT_W'(POS_DST_IP) && pos < CNT_W'(IP_MIN_END)) begin
         if (b != ip_sel) dst_ip_eq_in = 1'b0;
      end else begin
      end

      if (in_port && (b != port_sel)) begin
         if (port_off[1]) dst_port_eq_in = 1'b0;
         else             src_port_eq_in = 1'b0;
      end
   end

   always_comb begin
      priority if (filter_mode_ff == MODE_NONE) begin
         verdict = 1'b1;
      end else if (frame_len < (CNT_W+1)'(ETH_HDR)) begin
         verdict = 1'b0;
      end else if (filter_mode_ff == MODE_MAC) begin
         verdict = dst_mac_eq_in || src_mac_eq_in;
      end else if (filter_mode_ff == MODE_ETYPE) begin
         verdict = (type_field_in == match_etype_ff);
      end else if (type_field_in != ETYPE_IPV4) begin
         verdict = 1'b0;
      end else if (frame_len < (CNT_W+1)'(IP_MIN_END)) begin
         verdict = 1'b0;
      end else if (filter_mode_ff == MODE_IP) begin
         verdict = src_ip_eq_in || dst_ip_eq_in;
      end else if (filter_mode_ff == MODE_PROTO) begin
         verdict = (proto_field_in == match_proto_ff);
      end else if (filter_mode_ff == MODE_PORT) begin
         verdict = ((proto_field_in == PROTO_TCP) || (proto_field_in == PROTO_UDP)) &&
                   (frame_len >= (CNT_W+1)'(ETH_HDR + 4) +
                                 (CNT_W+1)'({header_words_in, 2'b00})) &&
                   (src_port_eq_in || dst_port_eq_in);
      end else begin
         verdict = 1'b1;
      end
   end

   always_comb begin
      if (pos < CNT_W'(COUNT_SATURATE)) byte_index_in = pos + CNT_W'(1);
      else                              byte_index_in = pos;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      keep_in      = keep_ff;
      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
         keep_in      = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff <= MODE_NONE;
         match_mac_ff   <= '0;
         match_etype_ff <= '0;
         match_ip_ff    <= '0;
         match_proto_ff <= '0;
         match_port_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FILTER_MODE: filter_mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_MATCH_MAC:   match_mac_ff   <= csr_wdata[MAC_W-1:0];
            CSR_MATCH_ETYPE: match_etype_ff <= csr_wdata[ETYPE_W-1:0];
            CSR_MATCH_IP:    match_ip_ff    <= csr_wdata[IP_W-1:0];
            CSR_MATCH_PROTO: match_proto_ff <= csr_wdata[PROTO_W-1:0];
            CSR_MATCH_PORT:  match_port_ff  <= csr_wdata[PORT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         byte_index_ff   <= '0;
         dst_mac_eq_ff   <= 1'b1;
         src_mac_eq_ff   <= 1'b1;
         type_field_ff   <= '0;
         header_words_ff <= '0;
         proto_field_ff  <= '0;
         src_ip_eq_ff    <= 1'b1;
         dst_ip_eq_ff    <= 1'b1;
         src_port_eq_ff  <= 1'b1;
         dst_port_eq_ff  <= 1'b1;
      end else if (accept) begin
         byte_index_ff   <= byte_index_in;
         dst_mac_eq_ff   <= dst_mac_eq_in;
         src_mac_eq_ff   <= src_mac_eq_in;
         type_field_ff   <= type_field_in;
         header_words_ff <= header_words_in;
         proto_field_ff  <= proto_field_in;
         src_ip_eq_ff    <= src_ip_eq_in;
         dst_ip_eq_ff    <= dst_ip_eq_in;
         src_port_eq_ff  <= src_port_eq_in;
         dst_port_eq_ff  <= dst_port_eq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) keep_ff <= 1'b0;
      else       keep_ff <= keep_in;
   end

endmodule

### rtl/efcf_checker.sv
`timescale 1ns / 1ps

module efcf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [7:0]                      rsp_tdata
);

   logic frame_end;
   logic rsp_stall;

   assign frame_end = req_tvalid && req_tready && req_tlast;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("verdict changed while stalled");

   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> rsp_tvalid)
      else $error("no verdict after frame end");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall && !frame_end |=> !rsp_tvalid)
      else $error("verdict without frame end");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |-> !req_tready)
      else $error("byte taken while verdict stalled");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("verdict padding not zero");

endmodule

bind ethernet_frame_capture_filter_top efcf_checker u_efcf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### verif/tb_ethernet_frame_capture_filter_top.sv
`timescale 1ns / 1ps

module tb_ethernet_frame_capture_filter_top;
   import efcf_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
   localparam int LONG_HOLD = 160;
   localparam int TAIL_WAIT = 8;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [7:0]           rsp_tdata;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   ethernet_frame_capture_filter_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   logic [MODE_W-1:0]  cfg_mode;
   logic [MAC_W-1:0]   cfg_mac;
   logic [ETYPE_W-1:0] cfg_etype;
   logic [IP_W-1:0]    cfg_ip;
   logic [PROTO_W-1:0] cfg_proto;
   logic [PORT_W-1:0]  cfg_port;

   count_type          frame_pos;
   logic               dst_mac_hit;
   logic               src_mac_hit;
   logic               src_ip_hit;
   logic               dst_ip_hit;
   logic               src_port_hit;
   logic               dst_port_hit;
   logic [ETYPE_W-1:0] ether_type;
   logic [3:0]         ihl;
   logic [PROTO_W-1:0] ip_proto;

   logic       expected_verdicts[$];
   logic [7:0] frame_bytes[$];
   logic       verdict_want;

   int error_count      = 0;
   int bytes_sent       = 0;
   int frames_sent      = 0;
   int verdicts_checked = 0;
   int keeps_seen       = 0;
   bit req_idle_on      = 1'b1;
   bit rsp_idle_on      = 1'b1;
   bit long_hold        = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TIMEOUT at %0t, %0d verdicts still pending", $time, expected_verdicts.size());
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      error_count++;
   endtask

   function automatic void clear_frame_state();
      frame_pos    = '0;
      dst_mac_hit  = 1'b1;
      src_mac_hit  = 1'b1;
      src_ip_hit   = 1'b1;
      dst_ip_hit   = 1'b1;
      src_port_hit = 1'b1;
      dst_port_hit = 1'b1;
      ether_type   = '0;
      ihl          = '0;
      ip_proto     = '0;
   endfunction

   function automatic logic frame_verdict(input int len);
      if (cfg_mode == MODE_NONE) return 1'b1;
      if (len < ETH_HDR) return 1'b0;
      if (cfg_mode == MODE_MAC) return dst_mac_hit || src_mac_hit;
      if (cfg_mode == MODE_ETYPE) return ether_type == cfg_etype;
      if (ether_type != ETYPE_IPV4) return 1'b0;
      if (len < IP_MIN_END) return 1'b0;
      if (cfg_mode == MODE_IP) return src_ip_hit || dst_ip_hit;
      if (cfg_mode == MODE_PROTO) return ip_proto == cfg_proto;
      if (cfg_mode == MODE_PORT) begin
         if (ip_proto != PROTO_TCP && ip_proto != PROTO_UDP) return 1'b0;
         if (len < ETH_HDR + 4 * int'(ihl) + 4) return 1'b0;
         return src_port_hit || dst_port_hit;
      end
      return 1'b1;
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic last);
      int pos;
      int port_at;
      pos = int'(frame_pos);
      if (pos < POS_SRC_MAC) begin
         if (b != cfg_mac[8*(5-pos) +: 8]) dst_mac_hit = 1'b0;
      end else if (pos < POS_TYPE_HI) begin
         if (b != cfg_mac[8*(11-pos) +: 8]) src_mac_hit = 1'b0;
      end else if (pos == POS_TYPE_HI) begin
         ether_type[15:8] = b;
      end else if (pos == POS_TYPE_LO) begin
         ether_type[7:0] = b;
      end else if (pos == ETH_HDR) begin
         ihl = b[3:0] & IHL_MASK;
      end else if (pos == POS_PROTO) begin
         ip_proto = b;
      end else if (pos >= POS_SRC_IP && pos < POS_DST_IP) begin
         if (b != cfg_ip[8*(POS_DST_IP-1-pos) +: 8]) src_ip_hit = 1'b0;
      end else if (pos >= POS_DST_IP && pos < IP_MIN_END) begin
         if (b != cfg_ip[8*(IP_MIN_END-1-pos) +: 8]) dst_ip_hit = 1'b0;
      end
      port_at = ETH_HDR + 4 * int'(ihl);
      if (pos >= ETH_HDR && pos >= port_at && pos < port_at + 4) begin
         if (pos < port_at + 2) begin
            if (b != cfg_port[8*(port_at+1-pos) +: 8]) src_port_hit = 1'b0;
         end else if (b != cfg_port[8*(port_at+3-pos) +: 8]) begin
            dst_port_hit = 1'b0;
         end
      end
      if (last) begin
         expected_verdicts.push_back(frame_verdict(pos + 1));
         clear_frame_state();
      end else if (pos < COUNT_SATURATE) begin
         frame_pos = frame_pos + CNT_W'(1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         verdicts_checked++;
         if (rsp_tdata[0] === 1'b1) keeps_seen++;
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict %0h with no frame pending", rsp_tdata));
         end else begin
            verdict_want = expected_verdicts.pop_front();
            if (rsp_tdata !== {7'd0, verdict_want})
               report_mismatch($sformatf("verdict %0h, expected keep=%0b",
                                         rsp_tdata, verdict_want));
         end
      end
   end

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            for (int n = 0; n < LONG_HOLD; n++) @(posedge clock);
            long_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         send_word(frame_bytes[i], i == frame_bytes.size() - 1);
      frames_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_FILTER_MODE: cfg_mode  = value[MODE_W-1:0];
         CSR_MATCH_MAC:   cfg_mac   = value[MAC_W-1:0];
         CSR_MATCH_ETYPE: cfg_etype = value[ETYPE_W-1:0];
         CSR_MATCH_IP:    cfg_ip    = value[IP_W-1:0];
         CSR_MATCH_PROTO: cfg_proto = value[PROTO_W-1:0];
         CSR_MATCH_PORT:  cfg_port  = value[PORT_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic put_bytes(input int pos, input logic [47:0] value, input int n);
      for (int k = 0; k < n; k++)
         if (pos + k < frame_bytes.size()) frame_bytes[pos + k] = value[8*(n-1-k) +: 8];
   endtask

   task automatic start_frame(input int len, input logic [15:0] etype,
                              input logic [3:0] ihl_val, input logic [7:0] proto);
      frame_bytes.delete();
      repeat (len) frame_bytes.push_back(8'h00);
      put_bytes(POS_TYPE_HI, 48'(etype), 2);
      put_bytes(ETH_HDR, 48'({4'h4, ihl_val}), 1);
      put_bytes(POS_PROTO, 48'(proto), 1);
   endtask

   function automatic logic [47:0] aim_value(input logic [47:0] hit, input int n);
      logic [47:0] v;
      int sel;
      sel = $urandom_range(0, 19);
      v[31:0]  = $urandom;
      v[47:32] = 16'($urandom);
      if (sel < 9) begin
         v = hit;
      end else if (sel < 13) begin
         v = hit;
         v[$urandom_range(0, 8 * n - 1)] ^= 1'b1;
      end
      return v;
   endfunction

   function automatic logic [CSR_W-1:0] pick_setting();
      logic [CSR_W-1:0] v;
      int sel;
      sel = $urandom_range(0, 4);
      v[31:0]  = $urandom;
      v[47:32] = 16'($urandom);
      if (sel == 0) v = '0;
      else if (sel == 1) v = '1;
      return v;
   endfunction

   task automatic build_random_frame();
      int len;
      int sel;
      int port_at;
      logic [3:0] ihl_val;
      logic [7:0] proto;
      logic [15:0] etype;
      ihl_val = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
      port_at = ETH_HDR + 4 * int'(ihl_val);
      sel = $urandom_range(0, 99);
      if (sel < 55) len = $urandom_range(IP_MIN_END, 50);
      else if (sel < 75) len = $urandom_range(1, IP_MIN_END - 1);
      else if (sel < 90) len = $urandom_range(port_at + 2, port_at + 6);
      else len = $urandom_range(100, 140);
      frame_bytes.delete();
      repeat (len) frame_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 6) == 0) return;
      put_bytes(POS_DST_MAC, aim_value(cfg_mac, 6), 6);
      put_bytes(POS_SRC_MAC, aim_value(cfg_mac, 6), 6);
      sel = $urandom_range(0, 9);
      etype = (sel < 6) ? ETYPE_IPV4 : (sel < 8) ? cfg_etype : 16'($urandom);
      put_bytes(POS_TYPE_HI, 48'(etype), 2);
      put_bytes(ETH_HDR, 48'({4'($urandom), ihl_val}), 1);
      sel = $urandom_range(0, 9);
      proto = (sel < 3) ? PROTO_TCP : (sel < 6) ? PROTO_UDP :
              (sel < 8) ? cfg_proto : 8'($urandom);
      put_bytes(POS_PROTO, 48'(proto), 1);
      put_bytes(POS_SRC_IP, aim_value(48'(cfg_ip), 4), 4);
      put_bytes(POS_DST_IP, aim_value(48'(cfg_ip), 4), 4);
      put_bytes(port_at, aim_value(48'(cfg_port), 2), 2);
      put_bytes(port_at + 2, aim_value(48'(cfg_port), 2), 2);
   endtask

   task automatic test_reset_state();
      frame_bytes.delete();
      frame_bytes.push_back(8'hFF);
      send_frame();
      start_frame(13, 16'h0000, 4'd0, 8'h00);
      send_frame();
      settle();
   endtask

   task automatic test_mac_mode();
      write_csr(CSR_FILTER_MODE, 48'(MODE_MAC));
      write_csr(CSR_MATCH_MAC, 48'hFFFF_FFFF_FFFF);
      start_frame(13, 16'h0000, 4'd0, 8'h00);
      put_bytes(POS_DST_MAC, cfg_mac, 6);
      send_frame();
      start_frame(14, 16'h0000, 4'd0, 8'h00);
      put_bytes(POS_DST_MAC, cfg_mac, 6);
      send_frame();
      start_frame(14, 16'h0000, 4'd0, 8'h00);
      put_bytes(POS_SRC_MAC, cfg_mac, 6);
      send_frame();
      start_frame(14, 16'h0000, 4'd0, 8'h00);
      put_bytes(POS_DST_MAC, 48'hFFFF_FFFF_FFFE, 6);
      send_frame();
      write_csr(CSR_MATCH_MAC, 48'h0);
      start_frame(20, 16'h0000, 4'd0, 8'h00);
      send_frame();
      settle();
   endtask

   task automatic test_ethertype_mode();
      write_csr(CSR_FILTER_MODE, 48'(MODE_ETYPE));
      write_csr(CSR_MATCH_ETYPE, 48'hFFFF);
      start_frame(14, 16'hFFFF, 4'd0, 8'h00);
      send_frame();
      start_frame(14, ETYPE_IPV4, 4'd0, 8'h00);
      send_frame();
      write_csr(CSR_MATCH_ETYPE, 48'h0);
      start_frame(13, 16'h0000, 4'd0, 8'h00);
      send_frame();
      settle();
   endtask

   task automatic test_ip_mode();
      write_csr(CSR_FILTER_MODE, 48'(MODE_IP));
      write_csr(CSR_MATCH_IP, 48'hC0A8_0001);
      start_frame(34, ETYPE_IPV4, 4'd5, PROTO_UDP);
      put_bytes(POS_DST_IP, 48'(cfg_ip), 4);
      send_frame();
      start_frame(33, ETYPE_IPV4, 4'd5, PROTO_UDP);
      put_bytes(POS_SRC_IP, 48'(cfg_ip), 4);
      send_frame();
      start_frame(40, 16'h86DD, 4'd5, PROTO_UDP);
      put_bytes(POS_SRC_IP, 48'(cfg_ip), 4);
      send_frame();
      start_frame(34, ETYPE_IPV4, 4'd5, PROTO_TCP);
      put_bytes(POS_SRC_IP, 48'(cfg_ip), 4);
      send_frame();
      start_frame(34, ETYPE_IPV4, 4'd5, PROTO_TCP);
      send_frame();
      settle();
   endtask

   task automatic test_protocol_mode();
      write_csr(CSR_FILTER_MODE, 48'(MODE_PROTO));
      write_csr(CSR_MATCH_PROTO, 48'hFF);
      start_frame(34, ETYPE_IPV4, 4'd5, 8'hFF);
      send_frame();
      start_frame(34, ETYPE_IPV4, 4'd5, 8'h00);
      send_frame();
      settle();
   endtask

   task automatic test_port_mode();
      write_csr(CSR_FILTER_MODE, 48'(MODE_PORT));
      write_csr(CSR_MATCH_PORT, 48'h4000);
      start_frame(38, ETYPE_IPV4, 4'd5, PROTO_TCP);
      put_bytes(IP_MIN_END + 2, 48'(cfg_port), 2);
      send_frame();
      start_frame(37, ETYPE_IPV4, 4'd5, PROTO_UDP);
      put_bytes(IP_MIN_END, 48'(cfg_port), 2);
      send_frame();
      start_frame(40, ETYPE_IPV4, 4'd5, 8'd1);
      put_bytes(IP_MIN_END, 48'(cfg_port), 2);
      send_frame();
      // zero header length: the port overlaps the IP header byte itself
      start_frame(34, ETYPE_IPV4, 4'd0, PROTO_UDP);
      send_frame();
      start_frame(77, ETYPE_IPV4, 4'd15, PROTO_TCP);
      put_bytes(74, 48'(cfg_port), 2);
      send_frame();
      start_frame(78, ETYPE_IPV4, 4'd15, PROTO_TCP);
      put_bytes(74, 48'(cfg_port), 2);
      send_frame();
      start_frame(140, ETYPE_IPV4, 4'd5, PROTO_TCP);
      put_bytes(IP_MIN_END, 48'(cfg_port), 2);
      send_frame();
      settle();
   endtask

   task automatic test_spare_modes();
      write_csr(CSR_FILTER_MODE, 48'(MODE_SPARE_LO));
      start_frame(34, ETYPE_IPV4, 4'd5, 8'h00);
      send_frame();
      start_frame(33, ETYPE_IPV4, 4'd5, 8'h00);
      send_frame();
      start_frame(40, 16'h0000, 4'd5, 8'h00);
      send_frame();
      write_csr(CSR_FILTER_MODE, 48'(MODE_SPARE_HI));
      start_frame(34, ETYPE_IPV4, 4'd5, 8'h00);
      send_frame();
      start_frame(1, 16'h0000, 4'd0, 8'h00);
      send_frame();
      settle();
   endtask

   task automatic test_backpressure();
      write_csr(CSR_FILTER_MODE, 48'(MODE_MAC));
      long_hold = 1'b1;
      for (int n = 0; n < 6; n++) begin
         start_frame($urandom_range(1, 20), ETYPE_IPV4, 4'd5, PROTO_TCP);
         if (n % 2 == 1) put_bytes(POS_SRC_MAC, cfg_mac, 6);
         send_frame();
      end
      settle();
   endtask

   task automatic test_random_traffic();
      int start_bytes;
      int phase_frames;
      logic [CSR_W-1:0] value;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase >= 6) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         write_csr(CSR_MATCH_MAC, pick_setting());
         write_csr(CSR_MATCH_ETYPE, pick_setting());
         write_csr(CSR_MATCH_IP, pick_setting());
         write_csr(CSR_MATCH_PROTO, pick_setting());
         write_csr(CSR_MATCH_PORT, pick_setting());
         value = pick_setting();
         value[MODE_W-1:0] = (phase < 8) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 7));
         write_csr(CSR_FILTER_MODE, value);
         start_bytes  = bytes_sent;
         phase_frames = 0;
         while (bytes_sent - start_bytes < 20 || phase_frames < 1) begin
            build_random_frame();
            send_frame();
            phase_frames++;
         end
         settle();
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_FILTER_MODE;
      csr_wdata  <= '0;
      cfg_mode   = MODE_NONE;
      cfg_mac    = '0;
      cfg_etype  = '0;
      cfg_ip     = '0;
      cfg_proto  = '0;
      cfg_port   = '0;
      clear_frame_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_mac_mode();
      test_ethertype_mode();
      test_ip_mode();
      test_protocol_mode();
      test_port_mode();
      test_spare_modes();
      test_backpressure();
      test_random_traffic();
      settle();

      $display("Sent %0d frames (%0d bytes) through every filter mode, unused codes, short,",
               frames_sent, bytes_sent);
      $display("saturating and back-pressured frames; %0d verdicts checked, %0d kept, %0d errors",
               verdicts_checked, keeps_seen, error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
